### sv/cfcr_pkg.sv
// shared types, constants and crc helpers for the crc32 frame check block
package cfcr_pkg;

    localparam int HEADER_BYTES    = 20;
    localparam int MAX_FRAME_BYTES = 65507;
    localparam int INDEX_W         = 16;

    localparam logic [INDEX_W-1:0] HDR_BYTES_IDX = INDEX_W'(HEADER_BYTES);
    localparam logic [INDEX_W-1:0] HDR_LAST_IDX  = INDEX_W'(HEADER_BYTES - 1);
    localparam logic [INDEX_W-1:0] MAX_IDX       = INDEX_W'(MAX_FRAME_BYTES);

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] ACK_CODE = 32'hFFF0_0FFF;

    // header word slots, little-endian words of four bytes each
    localparam logic [2:0] WORD_SEQ   = 3'd0;
    localparam logic [2:0] WORD_TOTAL = 3'd1;
    localparam logic [2:0] WORD_LEN   = 3'd2;
    localparam logic [2:0] WORD_CHK   = 3'd3;

    // per-word verdict from the frame tracker
    typedef struct packed {
        logic        pay;
        logic        ok;
        logic [31:0] seq;
        logic [31:0] total;
        logic [31:0] length;
        logic        is_ack;
    } t_frame_info;

    // reflected crc-32, one byte, eight unrolled shift steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] lane,
                                             input logic [7:0] b);
        logic [31:0] w;
        w = word;
        w[{lane, 3'b000} +: 8] = b;
        return w;
    endfunction

endpackage

### sv/cfcr_frame.sv
// frame position, header capture and running crc with the end-of-frame check
module cfcr_frame (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output cfcr_pkg::t_frame_info o_info
);

    logic [cfcr_pkg::INDEX_W-1:0] r_byte_index;
    logic [31:0] r_crc;
    logic [31:0] r_seq, r_total, r_len, r_chk, r_flags;

    logic [31:0] n_seq, n_total, n_len, n_chk, n_flags;
    logic [31:0] w_crc_next;
    logic [7:0]  w_crc_in;
    logic        w_first;
    logic        w_in_hdr;
    logic [2:0]  w_word;
    logic [1:0]  w_lane;

    assign w_first  = (r_byte_index == '0);
    assign w_in_hdr = (r_byte_index < cfcr_pkg::HDR_BYTES_IDX);
    assign w_word   = r_byte_index[4:2];
    assign w_lane   = r_byte_index[1:0];

    always_comb begin
        // header words start from zero at every frame start
        n_seq    = w_first ? '0 : r_seq;
        n_total  = w_first ? '0 : r_total;
        n_len    = w_first ? '0 : r_len;
        n_chk    = w_first ? '0 : r_chk;
        n_flags  = w_first ? '0 : r_flags;
        w_crc_in = i_byte;
        if (w_in_hdr) begin
            unique case (w_word)
                cfcr_pkg::WORD_SEQ:   n_seq   = cfcr_pkg::put_byte(n_seq, w_lane, i_byte);
                cfcr_pkg::WORD_TOTAL: n_total = cfcr_pkg::put_byte(n_total, w_lane, i_byte);
                cfcr_pkg::WORD_LEN:   n_len   = cfcr_pkg::put_byte(n_len, w_lane, i_byte);
                cfcr_pkg::WORD_CHK: begin
                    n_chk    = cfcr_pkg::put_byte(n_chk, w_lane, i_byte);
                    w_crc_in = '0;
                end
                default:              n_flags = cfcr_pkg::put_byte(n_flags, w_lane, i_byte);
            endcase
        end
    end

    assign w_crc_next = cfcr_pkg::crc_byte(r_crc, w_crc_in);

    always_comb begin
        o_info.pay    = !w_in_hdr;
        o_info.ok     = (r_byte_index >= cfcr_pkg::HDR_LAST_IDX)
                     && (r_byte_index < cfcr_pkg::MAX_IDX)
                     && (~w_crc_next == n_chk);
        o_info.seq    = n_seq;
        o_info.total  = n_total;
        o_info.length = n_len;
        o_info.is_ack = (n_flags == cfcr_pkg::ACK_CODE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_crc        <= cfcr_pkg::CRC_INIT;
            r_seq        <= '0;
            r_total      <= '0;
            r_len        <= '0;
            r_chk        <= '0;
            r_flags      <= '0;
        end else if (i_step) begin
            r_seq   <= n_seq;
            r_total <= n_total;
            r_len   <= n_len;
            r_chk   <= n_chk;
            r_flags <= n_flags;
            if (i_last) begin
                r_byte_index <= '0;
                r_crc        <= cfcr_pkg::CRC_INIT;
            end else begin
                r_crc <= w_crc_next;
                if (r_byte_index < cfcr_pkg::MAX_IDX) begin
                    r_byte_index <= r_byte_index + cfcr_pkg::INDEX_W'(1);
                end
            end
        end
    end

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> r_byte_index == '0 && r_crc == cfcr_pkg::CRC_INIT)
        else $error("frame tracker did not restart after frame end");

    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index <= cfcr_pkg::MAX_IDX)
        else $error("byte index past saturation bound");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_byte_index) && $stable(r_crc))
        else $error("frame state moved without a word");

endmodule

### sv/cfcr_order.sv
// in-order fragment counter: acceptance and message completion
module cfcr_order (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_last,
    input  logic        i_ok,
    input  logic [31:0] i_seq,
    input  logic [31:0] i_total,
    output logic        o_accepted,
    output logic        o_complete
);

    logic [31:0] r_count;
    logic [31:0] w_expect;
    logic [31:0] w_count_after;

    assign w_expect      = r_count + 32'd1;
    assign o_accepted    = i_ok && (i_seq == w_expect);
    assign w_count_after = o_accepted ? w_expect : r_count;
    assign o_complete    = i_ok && (w_count_after == i_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_step && i_last && i_ok) begin
            r_count <= o_complete ? '0 : w_count_after;
        end
    end

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last && o_complete |=> r_count == '0)
        else $error("count not cleared on completion");

    a_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last && o_accepted && !o_complete |=> r_count == $past(w_expect))
        else $error("count not advanced on acceptance");

    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_step && i_last) |=> $stable(r_count))
        else $error("count moved outside a frame end");

endmodule

### sv/crc32_frame_check_reassembly.sv
// top level: crc-32 checked frame receiver with in-order fragment counting
//
// input channel: one frame byte per word (i_rx_byte) with i_last_byte on the
// final byte, handshake i_in_valid / o_in_ready. output channel: one result
// word per input word, handshake o_out_valid / i_out_ready.
// every byte yields a result; payload bytes (position 20 onwards) come out
// with o_payload_valid set. on the last byte o_frame_end is set and the
// verdict fields carry the header words, the crc check, acceptance of the
// fragment and message completion; otherwise they read zero.
// a word taken into the input register moves on to the result register, with
// o_out_valid high, once the result slot is free. throughput: one word per
// cycle while the receiver does not stall, set by the unrolled 8-bit crc
// update between the two registers.
// reset (synchronous, active low) empties both registers, returns the frame
// position to zero, the crc to all ones and the fragment count to zero.
// when the receiver stalls the result register holds; the input register
// still takes one more word, and o_in_ready falls only when both are full.
module crc32_frame_check_reassembly (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_payload_byte,
    output logic        o_payload_valid,
    output logic        o_frame_end,
    output logic        o_checksum_ok,
    output logic [31:0] o_sequence_res,
    output logic [31:0] o_fragment_total,
    output logic [31:0] o_payload_length,
    output logic        o_is_ack,
    output logic        o_accepted,
    output logic        o_message_complete
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // result register
    logic        r_out_valid;
    logic [7:0]  r_payload_byte;
    logic        r_payload_valid;
    logic        r_frame_end;
    logic        r_checksum_ok;
    logic [31:0] r_sequence_res;
    logic [31:0] r_fragment_total;
    logic [31:0] r_payload_length;
    logic        r_is_ack;
    logic        r_accepted;
    logic        r_message_complete;

    logic                  w_adv;
    logic                  w_step;
    logic                  w_take;
    logic                  w_acc;
    logic                  w_done;
    cfcr_pkg::t_frame_info w_info;

    // result slot frees when empty or being taken this cycle
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_take     = i_in_valid && o_in_ready;

    cfcr_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_info  (w_info)
    );

    cfcr_order u_order (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_last     (r_in_last),
        .i_ok       (w_info.ok),
        .i_seq      (w_info.seq),
        .i_total    (w_info.total),
        .o_accepted (w_acc),
        .o_complete (w_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_rx_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    // verdict fields read zero away from frame end
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_payload_byte     <= w_info.pay ? r_in_byte : 8'd0;
            r_payload_valid    <= w_info.pay;
            r_frame_end        <= r_in_last;
            r_checksum_ok      <= r_in_last && w_info.ok;
            r_sequence_res     <= r_in_last ? w_info.seq : 32'd0;
            r_fragment_total   <= r_in_last ? w_info.total : 32'd0;
            r_payload_length   <= r_in_last ? w_info.length : 32'd0;
            r_is_ack           <= r_in_last && w_info.is_ack;
            r_accepted         <= r_in_last && w_acc;
            r_message_complete <= r_in_last && w_done;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_payload_byte     = r_payload_byte;
    assign o_payload_valid    = r_payload_valid;
    assign o_frame_end        = r_frame_end;
    assign o_checksum_ok      = r_checksum_ok;
    assign o_sequence_res     = r_sequence_res;
    assign o_fragment_total   = r_fragment_total;
    assign o_payload_length   = r_payload_length;
    assign o_is_ack           = r_is_ack;
    assign o_accepted         = r_accepted;
    assign o_message_complete = r_message_complete;

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("result lost after a step");

    a_inhold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("input register dropped a stalled word");

    a_accok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_accepted || r_message_complete) |-> r_checksum_ok && r_frame_end)
        else $error("fragment accepted without a good frame end");

    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_frame_end |-> !r_checksum_ok && !r_is_ack && r_sequence_res == '0)
        else $error("verdict fields set away from frame end");

endmodule

### tb/tb_crc32_frame_check_reassembly.sv
// testbench for the crc-32 checked frame receiver: directed and random frames against a predictor
module tb_crc32_frame_check_reassembly;

    localparam logic [31:0] REFLECTED_POLY = 32'hEDB8_8320;
    localparam int          RANDOM_BYTES   = 830;
    localparam int          SHOWN_FAILURES = 10;

    // what can go wrong with a frame in the random part
    typedef enum int {
        FAULT_NONE,
        FAULT_CRC,
        FAULT_SEQ,
        FAULT_SHORT,
        FAULT_NOISE
    } t_frame_fault;

    // one result word, fields in port order
    typedef struct packed {
        logic [7:0]  pbyte;
        logic        pvalid;
        logic        fend;
        logic        ok;
        logic [31:0] seq;
        logic [31:0] total;
        logic [31:0] len;
        logic        ack;
        logic        acc;
        logic        done;
    } t_frame_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_payload_byte;
    logic        o_payload_valid;
    logic        o_frame_end;
    logic        o_checksum_ok;
    logic [31:0] o_sequence_res;
    logic [31:0] o_fragment_total;
    logic [31:0] o_payload_length;
    logic        o_is_ack;
    logic        o_accepted;
    logic        o_message_complete;

    crc32_frame_check_reassembly uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_rx_byte          (i_rx_byte),
        .i_last_byte        (i_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_payload_byte     (o_payload_byte),
        .o_payload_valid    (o_payload_valid),
        .o_frame_end        (o_frame_end),
        .o_checksum_ok      (o_checksum_ok),
        .o_sequence_res     (o_sequence_res),
        .o_fragment_total   (o_fragment_total),
        .o_payload_length   (o_payload_length),
        .o_is_ack           (o_is_ack),
        .o_accepted         (o_accepted),
        .o_message_complete (o_message_complete)
    );

    // predictor state, a private copy of the receiver
    int          rx_pos;
    logic [31:0] run_crc;
    logic [31:0] hdr_words [5];
    logic [31:0] in_order_count;

    t_frame_result expected_words [$];
    logic [7:0]    frame_bytes [$];
    int            fail_count;
    int            stall_left;
    bit            in_idle_on;
    bit            out_stall_on;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // crc-32, reflected, one bit at a time lsb first
    function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] d);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[i];
            c  = c >> 1;
            if (fb)
                c = c ^ REFLECTED_POLY;
        end
        return c;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // expected result of one accepted word; advances the predictor
    function automatic t_frame_result predict_word(input logic [7:0] b, input logic last);
        t_frame_result r;
        logic [7:0]    crc_in;
        logic          good;
        r      = '0;
        crc_in = b;
        if (rx_pos == 0)
            hdr_words = '{default: 32'h0};
        if (rx_pos < cfcr_pkg::HEADER_BYTES) begin
            hdr_words[rx_pos / 4][(rx_pos % 4) * 8 +: 8] = b;
            // checksum bytes enter the crc as zero
            if (rx_pos / 4 == 3)
                crc_in = 8'h00;
        end
        run_crc = crc32_update(run_crc, crc_in);
        if (rx_pos >= cfcr_pkg::HEADER_BYTES) begin
            r.pbyte  = b;
            r.pvalid = 1'b1;
        end
        if (last) begin
            good = (rx_pos >= cfcr_pkg::HEADER_BYTES - 1)
                   && (rx_pos < cfcr_pkg::MAX_FRAME_BYTES)
                   && (~run_crc == hdr_words[3]);
            r.fend  = 1'b1;
            r.ok    = good;
            r.seq   = hdr_words[0];
            r.total = hdr_words[1];
            r.len   = hdr_words[2];
            r.ack   = (hdr_words[4] == cfcr_pkg::ACK_CODE);
            if (good) begin
                if (hdr_words[0] == in_order_count + 32'd1) begin
                    r.acc          = 1'b1;
                    in_order_count = in_order_count + 32'd1;
                end
                // completion also fires on a frame that was not the next one
                if (in_order_count == hdr_words[1]) begin
                    r.done         = 1'b1;
                    in_order_count = 32'd0;
                end
            end
            rx_pos  = 0;
            run_crc = '1;
        end else if (rx_pos < cfcr_pkg::MAX_FRAME_BYTES) begin
            rx_pos++;
        end
        return r;
    endfunction

    function automatic string format_word(input t_frame_result r);
        return $sformatf("byte %h pv %b end %b ok %b seq %h tot %h len %h ack %b acc %b cmp %b",
                         r.pbyte, r.pvalid, r.fend, r.ok, r.seq, r.total, r.len,
                         r.ack, r.acc, r.done);
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= SHOWN_FAILURES)
            $display("%0t: %s", $realtime, msg);
    endtask

    // one word on the input channel, predicted at the edge that takes it
    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        gap = in_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_rx_byte   <= b;
        i_last_byte <= last;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        expected_words.insert(expected_words.size(), predict_word(b, last));
    endtask

    // checksum over the frame with its checksum bytes taken as zero, written into bytes 12..15
    task automatic seal_frame(input bit bad_crc);
        logic [31:0] c;
        c = '1;
        foreach (frame_bytes[i])
            c = crc32_update(c, (i >= 12 && i < 16) ? 8'h00 : frame_bytes[i]);
        c = ~c;
        if (bad_crc)
            c = c ^ (32'h1 << $urandom_range(0, 31));
        for (int l = 0; l < 4; l++)
            frame_bytes[12 + l] = c[l * 8 +: 8];
    endtask

    task automatic build_frame(input logic [31:0] seq, input logic [31:0] total,
                               input logic [31:0] len_field, input logic [31:0] flags,
                               input int n_pay, input bit bad_crc);
        logic [31:0] words [5];
        words = '{seq, total, len_field, 32'h0, flags};
        frame_bytes.delete();
        for (int w = 0; w < 5; w++)
            for (int l = 0; l < 4; l++)
                frame_bytes.insert(frame_bytes.size(), words[w][l * 8 +: 8]);
        for (int i = 0; i < n_pay; i++)
            frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(0, 255)));
        seal_frame(bad_crc);
    endtask

    // sends the first n bytes of the built frame, last mark on the final one
    task automatic send_frame(input int n);
        for (int i = 0; i < n; i++)
            send_word(frame_bytes[i], i == n - 1);
    endtask

    task automatic test_short_frames();
        // single byte frame, a partial header of all ones, then a six-byte partial header
        build_frame(32'h1, 32'h1, 32'h0, 32'h0, 0, 1'b0);
        send_frame(1);
        build_frame('1, '1, '1, '1, 0, 1'b0);
        send_frame(cfcr_pkg::HEADER_BYTES - 1);
        build_frame(32'h1, 32'h1, 32'h0, cfcr_pkg::ACK_CODE, 0, 1'b0);
        send_frame(6);
    endtask

    task automatic test_in_order_message();
        // three fragments, the first carries payload extremes, the last has no payload
        build_frame(32'd1, 32'd3, 32'd4, cfcr_pkg::ACK_CODE, 4, 1'b0);
        frame_bytes[cfcr_pkg::HEADER_BYTES]     = 8'h00;
        frame_bytes[cfcr_pkg::HEADER_BYTES + 1] = 8'hFF;
        seal_frame(1'b0);
        send_frame(frame_bytes.size());
        build_frame(32'd2, 32'd3, '1, 32'h0, 3, 1'b0);
        send_frame(frame_bytes.size());
        build_frame(32'd3, 32'd3, 32'd0, '1, 0, 1'b0);
        send_frame(frame_bytes.size());
    endtask

    task automatic test_rejected_frames();
        // bad checksum, then a good frame out of order, then extreme header words
        build_frame(32'd1, 32'd2, 32'd2, cfcr_pkg::ACK_CODE, 2, 1'b1);
        send_frame(frame_bytes.size());
        build_frame(32'd5, 32'd2, 32'd1, 32'h0, 1, 1'b0);
        send_frame(frame_bytes.size());
        build_frame('1, '1, '1, '1, 1, 1'b0);
        send_frame(frame_bytes.size());
    endtask

    task automatic test_completion_cases();
        // zero total completes at once on a good frame
        build_frame(32'd9, 32'd0, 32'd0, 32'h0, 0, 1'b0);
        send_frame(frame_bytes.size());
        // one accepted, then a stray frame whose total matches the count
        build_frame(32'd1, 32'd2, 32'd0, 32'h0, 1, 1'b0);
        send_frame(frame_bytes.size());
        build_frame(32'd7, 32'd1, 32'd0, 32'h0, 1, 1'b0);
        send_frame(frame_bytes.size());
    endtask

    task automatic test_random_messages();
        int           sent;
        int           n;
        int           r;
        int           n_pay;
        logic [31:0]  first;
        logic [31:0]  total;
        logic [31:0]  seq;
        logic [31:0]  flags;
        t_frame_fault fault;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            // some messages run without any idling on either side
            in_idle_on   = ($urandom_range(0, 3) != 0);
            out_stall_on = ($urandom_range(0, 3) != 0);
            first = in_order_count + 32'd1;
            total = in_order_count + 32'($urandom_range(1, 4));
            for (logic [31:0] s = first; s <= total; s++) begin
                r = $urandom_range(0, 99);
                fault = (r < 75) ? FAULT_NONE  : (r < 83) ? FAULT_CRC :
                        (r < 90) ? FAULT_SEQ   : (r < 95) ? FAULT_SHORT : FAULT_NOISE;
                n_pay = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200)
                                                     : $urandom_range(0, 24);
                flags = ($urandom_range(0, 3) == 0) ? cfcr_pkg::ACK_CODE : $urandom;
                seq   = (fault == FAULT_SEQ) ? 32'($urandom_range(0, total + 2)) : s;
                build_frame(seq, total, $urandom, flags, n_pay, fault == FAULT_CRC);
                n = (fault == FAULT_SHORT) ? $urandom_range(1, cfcr_pkg::HEADER_BYTES - 1)
                                           : frame_bytes.size();
                if (fault == FAULT_NOISE) begin
                    // a frame of random bytes only
                    n = $urandom_range(1, 40);
                    frame_bytes.delete();
                    for (int i = 0; i < n; i++)
                        frame_bytes.insert(i, 8'($urandom_range(0, 255)));
                end
                send_frame(n);
                sent += n;
            end
        end
    endtask

    // receiver side, stalls of random length
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!out_stall_on || $urandom_range(0, 99) < 70) begin
            i_out_ready <= 1'b1;
        end else begin
            stall_left = pick_gap();
            i_out_ready <= 1'b0;
        end
    end

    // each result word against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_frame_result got;
        t_frame_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_payload_byte, o_payload_valid, o_frame_end, o_checksum_ok,
                   o_sequence_res, o_fragment_total, o_payload_length,
                   o_is_ack, o_accepted, o_message_complete};
            if (expected_words.size() == 0) begin
                report_failure({"unexpected word: ", format_word(got)});
            end else begin
                want = expected_words.pop_front();
                if (got.pbyte !== want.pbyte || got.pvalid !== want.pvalid
                    || got.fend !== want.fend || got.ok !== want.ok
                    || got.seq !== want.seq || got.total !== want.total
                    || got.len !== want.len || got.ack !== want.ack
                    || got.acc !== want.acc || got.done !== want.done)
                    report_failure({"mismatch\n  exp ", format_word(want),
                                    "\n  got ", format_word(got)});
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_rx_byte      = 8'h00;
        i_last_byte    = 1'b0;
        i_out_ready    = 1'b0;
        rx_pos         = 0;
        run_crc        = '1;
        hdr_words      = '{default: 32'h0};
        in_order_count = 32'd0;
        fail_count     = 0;
        stall_left     = 0;
        in_idle_on     = 1'b1;
        out_stall_on   = 1'b1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_short_frames();
        test_in_order_message();
        test_rejected_frames();
        test_completion_cases();
        test_random_messages();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
        // catch any stray word behind the two-stage pipe
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // run limit, well above the slowest legal run
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
